// File: rtl/voxel_neighbour_index_generator_unit_defines.svh
// Assertion macros used by the voxel neighbour index generator top level.
`ifndef VOXEL_NEIGHBOUR_INDEX_GENERATOR_UNIT_DEFINES_SVH
`define VOXEL_NEIGHBOUR_INDEX_GENERATOR_UNIT_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define VNIG_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define VNIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vnig_pkg.sv
// Shared types, codes, offset tables and microcode ROM of the voxel neighbour generator.
package vnig_pkg;

  localparam int IDX_W       = 30;
  localparam int CMD_W       = 3;
  localparam int ST_W        = 2;
  localparam int SIZE_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int UPC_W       = 6;
  localparam int DEF_MAX_DIM = 1024;

  // Neighbourhood selection
  localparam logic [CMD_W-1:0] CMD_SIX     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FULL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RING_XY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RING_YZ = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RING_XZ = 3'd4;

  // Result status
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE    = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Per-axis offset codes, packed as {dx, dy, dz}
  localparam logic [1:0] D_ZERO = 2'b00;
  localparam logic [1:0] D_POS  = 2'b01;
  localparam logic [1:0] D_NEG  = 2'b11;

  typedef logic [5:0] ofs_t;

  localparam ofs_t TAB6 [6] = '{
    {D_NEG, D_ZERO, D_ZERO}, {D_POS, D_ZERO, D_ZERO}, {D_ZERO, D_NEG, D_ZERO},
    {D_ZERO, D_POS, D_ZERO}, {D_ZERO, D_ZERO, D_NEG}, {D_ZERO, D_ZERO, D_POS}
  };

  localparam ofs_t TAB27 [27] = '{
    {D_ZERO, D_ZERO, D_ZERO}, {D_ZERO, D_NEG, D_ZERO}, {D_ZERO, D_POS, D_ZERO},
    {D_NEG, D_ZERO, D_ZERO},  {D_NEG, D_NEG, D_ZERO},  {D_NEG, D_POS, D_ZERO},
    {D_POS, D_ZERO, D_ZERO},  {D_POS, D_NEG, D_ZERO},  {D_POS, D_POS, D_ZERO},
    {D_ZERO, D_ZERO, D_NEG},  {D_ZERO, D_NEG, D_NEG},  {D_ZERO, D_POS, D_NEG},
    {D_NEG, D_ZERO, D_NEG},   {D_NEG, D_NEG, D_NEG},   {D_NEG, D_POS, D_NEG},
    {D_POS, D_ZERO, D_NEG},   {D_POS, D_NEG, D_NEG},   {D_POS, D_POS, D_NEG},
    {D_ZERO, D_ZERO, D_POS},  {D_ZERO, D_NEG, D_POS},  {D_ZERO, D_POS, D_POS},
    {D_NEG, D_ZERO, D_POS},   {D_NEG, D_NEG, D_POS},   {D_NEG, D_POS, D_POS},
    {D_POS, D_ZERO, D_POS},   {D_POS, D_NEG, D_POS},   {D_POS, D_POS, D_POS}
  };

  localparam ofs_t TABXY [8] = '{
    {D_NEG, D_ZERO, D_ZERO}, {D_NEG, D_NEG, D_ZERO}, {D_ZERO, D_NEG, D_ZERO},
    {D_POS, D_NEG, D_ZERO},  {D_POS, D_ZERO, D_ZERO}, {D_POS, D_POS, D_ZERO},
    {D_ZERO, D_POS, D_ZERO}, {D_NEG, D_POS, D_ZERO}
  };

  localparam ofs_t TABYZ [8] = '{
    {D_ZERO, D_ZERO, D_NEG}, {D_ZERO, D_NEG, D_NEG}, {D_ZERO, D_NEG, D_ZERO},
    {D_ZERO, D_NEG, D_POS},  {D_ZERO, D_ZERO, D_POS}, {D_ZERO, D_POS, D_POS},
    {D_ZERO, D_POS, D_ZERO}, {D_ZERO, D_POS, D_NEG}
  };

  localparam ofs_t TABXZ [8] = '{
    {D_ZERO, D_ZERO, D_NEG}, {D_NEG, D_ZERO, D_NEG}, {D_NEG, D_ZERO, D_ZERO},
    {D_NEG, D_ZERO, D_POS},  {D_ZERO, D_ZERO, D_POS}, {D_POS, D_ZERO, D_POS},
    {D_POS, D_ZERO, D_ZERO}, {D_POS, D_ZERO, D_NEG}
  };

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV2,
    OP_CHECK,
    OP_EMIT,
    OP_FLUSH
  } op_e;

  // Sequencing of the step counter
  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_WAIT,
    SEQ_LOOP,
    SEQ_CHECK,
    SEQ_JUMP
  } seq_e;

  typedef struct packed {
    op_e  op;
    ofs_t ofs;
  } ctrl_t;

  typedef struct packed {
    seq_e             seq;
    ctrl_t            ctrl;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic div_done;
    logic outside;
  } stat_t;

  // Program layout
  localparam logic [UPC_W-1:0] UPC_WAIT   = 6'd0;
  localparam logic [UPC_W-1:0] UPC_DIVA   = 6'd1;
  localparam logic [UPC_W-1:0] UPC_DIV2   = 6'd2;
  localparam logic [UPC_W-1:0] UPC_DIVB   = 6'd3;
  localparam logic [UPC_W-1:0] UPC_CHECK  = 6'd4;
  localparam logic [UPC_W-1:0] UPC_TAB6   = 6'd5;
  localparam logic [UPC_W-1:0] UPC_TAB27  = UPC_TAB6 + 6'd6;
  localparam logic [UPC_W-1:0] UPC_TABXY  = UPC_TAB27 + 6'd27;
  localparam logic [UPC_W-1:0] UPC_TABYZ  = UPC_TABXY + 6'd8;
  localparam logic [UPC_W-1:0] UPC_TABXZ  = UPC_TABYZ + 6'd8;
  localparam logic [UPC_W-1:0] UPC_FLUSH  = UPC_TABXZ + 6'd8;

  function automatic logic [UPC_W-1:0] mode_entry(input logic [CMD_W-1:0] cmd);
    logic [UPC_W-1:0] e;
    unique case (cmd)
      CMD_SIX:     e = UPC_TAB6;
      CMD_FULL:    e = UPC_TAB27;
      CMD_RING_XY: e = UPC_TABXY;
      CMD_RING_YZ: e = UPC_TABYZ;
      CMD_RING_XZ: e = UPC_TABXZ;
      default:     e = UPC_FLUSH;
    endcase
    return e;
  endfunction

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] a);
    uword_t w;
    w.seq      = SEQ_JUMP;
    w.ctrl.op  = OP_NOP;
    w.ctrl.ofs = '0;
    w.target   = UPC_WAIT;
    if (a == UPC_WAIT) begin
      w.seq     = SEQ_WAIT;
      w.ctrl.op = OP_LOAD;
    end else if (a == UPC_DIVA || a == UPC_DIVB) begin
      w.seq = SEQ_LOOP;
    end else if (a == UPC_DIV2) begin
      w.seq     = SEQ_NEXT;
      w.ctrl.op = OP_DIV2;
    end else if (a == UPC_CHECK) begin
      w.seq     = SEQ_CHECK;
      w.ctrl.op = OP_CHECK;
    end else if (a >= UPC_TAB6 && a < UPC_FLUSH) begin
      w.ctrl.op = OP_EMIT;
      w.target  = UPC_FLUSH;
      w.seq     = SEQ_NEXT;
      if (a < UPC_TAB27) begin
        w.ctrl.ofs = TAB6[3'(a - UPC_TAB6)];
        if (a == UPC_TAB27 - 6'd1) begin
          w.seq = SEQ_JUMP;
        end
      end else if (a < UPC_TABXY) begin
        w.ctrl.ofs = TAB27[5'(a - UPC_TAB27)];
        if (a == UPC_TABXY - 6'd1) begin
          w.seq = SEQ_JUMP;
        end
      end else if (a < UPC_TABYZ) begin
        w.ctrl.ofs = TABXY[3'(a - UPC_TABXY)];
        if (a == UPC_TABYZ - 6'd1) begin
          w.seq = SEQ_JUMP;
        end
      end else if (a < UPC_TABXZ) begin
        w.ctrl.ofs = TABYZ[3'(a - UPC_TABYZ)];
        if (a == UPC_TABXZ - 6'd1) begin
          w.seq = SEQ_JUMP;
        end
      end else begin
        w.ctrl.ofs = TABXZ[3'(a - UPC_TABXZ)];
        if (a == UPC_FLUSH - 6'd1) begin
          w.seq = SEQ_JUMP;
        end
      end
    end else if (a == UPC_FLUSH) begin
      w.ctrl.op = OP_FLUSH;
    end else begin
      w.target = UPC_WAIT;
    end
    return w;
  endfunction

  // Linear step of one axis: zero, +stp or -stp (mod 2^IDX_W)
  function automatic logic [IDX_W-1:0] axis_term(input logic [1:0] code,
                                                 input logic [IDX_W-1:0] stp);
    logic [IDX_W-1:0] t;
    unique case (code)
      D_POS:   t = stp;
      D_NEG:   t = ~stp + IDX_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic axis_ok(input logic [1:0] code, input logic lo, input logic hi);
    return !((code == D_NEG) && lo) && !((code == D_POS) && hi);
  endfunction

endpackage

// File: rtl/vnig_div.sv
// Restoring divider that retires one quotient bit per cycle.
module vnig_div import vnig_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic [IDX_W-1:0]                     dividend_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]         divisor_i,
  output logic [IDX_W-1:0]                     quot_o,
  output logic [$clog2(MAX_DIM+1)-1:0]         rem_o,
  output logic                                 done_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [IDX_W-1:0] quo_q, quo_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [DIM_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W:0]   trial;

  always_comb begin
    trial = {rem_q, quo_q[IDX_W-1]};
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
      cnt_d = CNT_W'(IDX_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (trial >= {1'b0, den_q}) begin
        rem_d = DIM_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[IDX_W-2:0], 1'b1};
      end else begin
        rem_d = DIM_W'(trial);
        quo_d = {quo_q[IDX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = quo_q;
  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

// File: rtl/vnig_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
module vnig_seq import vnig_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  stat_t            stat_i,
  output ctrl_t            ctrl_o,
  output logic             busy_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  uword_t           uw;

  assign uw = ucode_rom(upc_q);

  always_comb begin
    upc_d  = upc_q;
    cmd_d  = cmd_q;
    ctrl_o = uw.ctrl;
    unique case (uw.seq)
      SEQ_WAIT: begin
        if (start_i) begin
          upc_d = upc_q + UPC_W'(1);
          cmd_d = cmd_i;
        end else begin
          ctrl_o.op = OP_NOP;
        end
      end
      SEQ_NEXT: upc_d = upc_q + UPC_W'(1);
      SEQ_LOOP: begin
        if (stat_i.div_done) begin
          upc_d = upc_q + UPC_W'(1);
        end
      end
      SEQ_CHECK: upc_d = stat_i.outside ? UPC_WAIT : mode_entry(cmd_q);
      SEQ_JUMP:  upc_d = uw.target;
      default:   upc_d = UPC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_WAIT;
      cmd_q <= '0;
    end else begin
      upc_q <= upc_d;
      cmd_q <= cmd_d;
    end
  end

  assign busy_o = (upc_q != UPC_WAIT);

endmodule

// File: rtl/vnig_dp.sv
// Datapath: index split through the divider, bounds flags, neighbour sum and result register.
module vnig_dp import vnig_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_t                        ctrl_i,
  input  logic [IDX_W-1:0]             voxel_index_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] nx_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] ny_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] nz_i,
  output stat_t                        stat_o,
  output logic                         result_valid_o,
  output logic [IDX_W-1:0]             neighbour_index_o,
  output logic [ST_W-1:0]              status_o,
  output logic                         last_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  typedef struct packed {
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
  } bnd_t;

  logic               div_load;
  logic [IDX_W-1:0]   div_dividend;
  logic [DIM_W-1:0]   div_divisor;
  logic [IDX_W-1:0]   quot;
  logic [DIM_W-1:0]   rem;
  logic               div_done;
  logic               outside;
  logic [2*DIM_W-1:0] plane_full;
  logic               nbr_ok;
  logic [IDX_W-1:0]   nbr_sum;

  logic [IDX_W-1:0] id_q, id_d;
  logic [IDX_W-1:0] plane_q, plane_d;
  bnd_t             bnd_q, bnd_d;
  logic [IDX_W-1:0] pend_q, pend_d;
  logic             pend_v_q, pend_v_d;
  logic             res_v_q, res_v_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic [ST_W-1:0]  res_st_q, res_st_d;
  logic             res_last_q, res_last_d;

  vnig_div #(
    .MAX_DIM(MAX_DIM)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (div_load),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .quot_o    (quot),
    .rem_o     (rem),
    .done_o    (div_done)
  );

  // First pass splits off x, second pass splits the remaining quotient into y and z.
  assign div_load     = (ctrl_i.op == OP_LOAD) || (ctrl_i.op == OP_DIV2);
  assign div_dividend = (ctrl_i.op == OP_DIV2) ? quot : voxel_index_i;
  assign div_divisor  = (ctrl_i.op == OP_DIV2) ? ny_i : nx_i;

  assign outside    = (quot >= IDX_W'(nz_i));
  assign stat_o     = '{div_done: div_done, outside: outside};
  assign plane_full = nx_i * ny_i;

  assign nbr_ok  = axis_ok(ctrl_i.ofs[5:4], bnd_q.x_lo, bnd_q.x_hi)
                && axis_ok(ctrl_i.ofs[3:2], bnd_q.y_lo, bnd_q.y_hi)
                && axis_ok(ctrl_i.ofs[1:0], bnd_q.z_lo, bnd_q.z_hi);
  assign nbr_sum = id_q + axis_term(ctrl_i.ofs[5:4], IDX_W'(1))
                        + axis_term(ctrl_i.ofs[3:2], IDX_W'(nx_i))
                        + axis_term(ctrl_i.ofs[1:0], plane_q);

  always_comb begin
    id_d       = id_q;
    plane_d    = plane_q;
    bnd_d      = bnd_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    res_v_d    = 1'b0;
    res_idx_d  = res_idx_q;
    res_st_d   = res_st_q;
    res_last_d = res_last_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        id_d     = voxel_index_i;
        pend_v_d = 1'b0;
      end
      OP_DIV2: begin
        plane_d    = IDX_W'(plane_full);
        bnd_d.x_lo = (rem == '0);
        bnd_d.x_hi = (rem == nx_i - DIM_W'(1));
      end
      OP_CHECK: begin
        bnd_d.y_lo = (rem == '0);
        bnd_d.y_hi = (rem == ny_i - DIM_W'(1));
        bnd_d.z_lo = (quot == '0);
        bnd_d.z_hi = (quot == IDX_W'(nz_i) - IDX_W'(1));
        if (outside) begin
          res_v_d    = 1'b1;
          res_idx_d  = '0;
          res_st_d   = ST_OUTSIDE;
          res_last_d = 1'b1;
        end
      end
      OP_EMIT: begin
        // Hold one neighbour back so the final one can carry the last flag.
        if (nbr_ok) begin
          if (pend_v_q) begin
            res_v_d    = 1'b1;
            res_idx_d  = pend_q;
            res_st_d   = ST_OK;
            res_last_d = 1'b0;
          end
          pend_d   = nbr_sum;
          pend_v_d = 1'b1;
        end
      end
      OP_FLUSH: begin
        res_v_d    = 1'b1;
        res_last_d = 1'b1;
        if (pend_v_q) begin
          res_idx_d = pend_q;
          res_st_d  = ST_OK;
        end else begin
          res_idx_d = '0;
          res_st_d  = ST_NONE;
        end
        pend_v_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    plane_q    <= plane_d;
    bnd_q      <= bnd_d;
    pend_q     <= pend_d;
    res_idx_q  <= res_idx_d;
    res_st_q   <= res_st_d;
    res_last_q <= res_last_d;
  end

  assign result_valid_o    = res_v_q;
  assign neighbour_index_o = res_idx_q;
  assign status_o          = res_st_q;
  assign last_o            = res_last_q;

endmodule

// File: rtl/voxel_neighbour_index_generator_unit.sv
// Top level of the voxel neighbour index generator: configuration, sequencer and datapath.
`include "voxel_neighbour_index_generator_unit_defines.svh"

// A request (cmd_i, voxel_index_i) is taken on a clock edge with start_i high and
// busy_o low. The index is split into x, y and z by two passes of a shared one-bit-per-
// cycle divider, then a microcoded step walks the selected offset list, one offset per
// cycle, and a final step closes the list. The list holds 6 offsets for the face set,
// 27 for the full block, 8 for a ring and none for an unused mode; an index outside the
// grid ends at the check step, with no walk. A new request can be taken in the first
// cycle busy_o is low again. Results come on result_valid_o for a single cycle each and
// cannot be stalled: the receiver must take every strobe. In-grid neighbours come in
// table order, the last one flagged by last_o; an empty list gives one status "none"
// result and an outside index one status "outside" result, both with a zero index. The
// last result of a request shows in the cycle busy_o falls. Grid sizes must be written
// through the cfg port only while busy_o is low; the block itself does not enforce it.
// A size of zero acts as one and a size above MAX_DIM acts as MAX_DIM.
module voxel_neighbour_index_generator_unit import vnig_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [IDX_W-1:0]     voxel_index_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  output logic                 result_valid_o,
  output logic [IDX_W-1:0]     neighbour_index_o,
  output logic [ST_W-1:0]      status_o,
  output logic                 last_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [SIZE_W-1:0] size_x_q, size_x_d;
  logic [SIZE_W-1:0] size_y_q, size_y_d;
  logic [SIZE_W-1:0] size_z_q, size_z_d;
  logic [DIM_W-1:0]  nx, ny, nz;
  ctrl_t             ctrl;
  stat_t             stat;
  logic              nonok_result;

  // Clamp a raw size register to the range the datapath is built for.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [SIZE_W-1:0] s);
    logic [DIM_W-1:0] r;
    if (s == '0) begin
      r = DIM_W'(1);
    end else if (32'(s) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(s);
    end
    return r;
  endfunction

  // Configuration writes are always taken; indexes past the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    size_x_d = size_x_q;
    size_y_d = size_y_q;
    size_z_d = size_z_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SIZE_X: size_x_d = cfg_data_i;
        CFG_SIZE_Y: size_y_d = cfg_data_i;
        CFG_SIZE_Z: size_z_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_W'(1);
      size_y_q <= SIZE_W'(1);
      size_z_q <= SIZE_W'(1);
    end else begin
      size_x_q <= size_x_d;
      size_y_q <= size_y_d;
      size_z_q <= size_z_d;
    end
  end

  assign nx = eff_dim(size_x_q);
  assign ny = eff_dim(size_y_q);
  assign nz = eff_dim(size_z_q);

  // Step counter and control ROM; advances through divide, check and emit phases.
  vnig_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  // Divider, bounds flags, neighbour adder and the one-cycle result register.
  vnig_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .voxel_index_i    (voxel_index_i),
    .nx_i             (nx),
    .ny_i             (ny),
    .nz_i             (nz),
    .stat_o           (stat),
    .result_valid_o   (result_valid_o),
    .neighbour_index_o(neighbour_index_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  assign nonok_result = result_valid_o && (status_o != ST_OK);

  // An accepted request always occupies the block for the following cycle.
  `VNIG_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "request taken but not busy")
  // No result can appear in the cycle after an idle cycle.
  `VNIG_ASSERT_NEXT(a_idle_quiet, !busy_o, !result_valid_o, "result without a request")
  // Only the closing result of a request drops busy.
  `VNIG_ASSERT_NOW(a_last_busy, result_valid_o |-> (last_o == !busy_o), "last flag off")
  // Error and empty results carry a zero index and close the request.
  `VNIG_ASSERT_NOW(a_status_last, nonok_result |-> last_o && neighbour_index_o == '0, "bad status")

endmodule
